// File: hw/rtl/ple_pkg.sv
// Package for the positional list engine: request and status codes.
// No dependencies; used by the top level positional_list_engine.
`default_nettype none

package ple_pkg;

    // request codes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_OVERFLOW = 3'd1;
    localparam logic [2:0] STAT_EMPTY    = 3'd2;
    localparam logic [2:0] STAT_BADPOS   = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

// File: hw/rtl/ple_store.sv
// Entry memory of the positional list engine: one write port, one read port,
// registered read data. No package dependency.
`default_nettype none

module ple_store #(
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [31:0]              wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [31:0]              rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/positional_list_engine.sv
// Positional list engine top level: request decode, memory walk sequencer,
// result register. Depends on ple_pkg and ple_store.
//
// Usage:
//   s_ channel carries one request (operation, position, value); m_ channel
//   returns exactly one result (status, found_index, read_value, entry_count)
//   per request, in order. Both use valid/ready; a transfer happens when both
//   are high.
//   Requests are handled one at a time; s_ready is high only while the
//   sequencer is idle. All list entries live in a single-port-read,
//   single-port-write memory with registered read data, and every shift or
//   compare is one entry per cycle through that memory:
//     clear, ignored codes and failed requests: no memory access
//     read:   one memory read
//     search: reads from the first entry up, stops at the first match
//     insert: shift entries from position up, top first, then write; append: write
//     delete: shift entries above position down; none when removing the last
//   The result register frees the sequencer: the next request is taken while
//   a result waits for m_ready. If a second result completes before the first
//   is taken, the sequencer holds it and stalls the input until m_ready.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result; memory contents are not cleared and need no clearing pass.
`default_nettype none

module positional_list_engine #(
    parameter int DEPTH = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_operation,
    input  wire logic [7:0]         s_position,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic [6:0]              m_found_index,
    output logic signed [31:0]      m_read_value,
    output logic [7:0]              m_entry_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > 8) ? CW : 8) + 1;
    localparam logic [CMPW-1:0] DEPTH_EXT = CMPW'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_FILL  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [2:0]     op_reg, op_next;
    logic [31:0]    val_reg, val_next;
    logic [AW-1:0]  rd_addr_reg, rd_addr_next;
    logic [AW-1:0]  last_reg, last_next;
    logic [AW-1:0]  pos_addr_reg, pos_addr_next;
    logic           down_reg, down_next;
    logic           s1_valid_reg, s1_valid_next;
    logic [AW-1:0]  s1_addr_reg, s1_addr_next;
    logic [2:0]     res_status_reg, res_status_next;
    logic [6:0]     res_found_reg, res_found_next;
    logic [31:0]    res_read_reg, res_read_next;
    logic           m_valid_reg, m_valid_next;
    logic [2:0]     m_status_reg, m_status_next;
    logic [6:0]     m_found_reg, m_found_next;
    logic [31:0]    m_read_reg, m_read_next;
    logic [7:0]     m_count_reg, m_count_next;

    logic           mem_wr_en;
    logic [AW-1:0]  mem_wr_addr;
    logic [31:0]    mem_wr_data;
    logic           mem_rd_en;
    logic [AW-1:0]  mem_rd_addr;
    logic [31:0]    mem_rd_data;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] count_ext;
    logic [AW-1:0]   pos_m1;
    logic [AW-1:0]   cnt_m1;
    logic            match;

    ple_store #(.DEPTH(DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign pos_ext   = CMPW'(s_position);
    assign count_ext = CMPW'(count_reg);
    assign pos_m1    = AW'(pos_ext - CMPW'(1));
    assign cnt_m1    = AW'(count_ext - CMPW'(1));
    assign match     = s1_valid_reg && (op_reg == ple_pkg::OP_SEARCH)
                       && (mem_rd_data == val_reg);

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_index = m_found_reg;
    assign m_read_value  = m_read_reg;
    assign m_entry_count = m_count_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        rd_addr_next    = rd_addr_reg;
        last_next       = last_reg;
        pos_addr_next   = pos_addr_reg;
        down_next       = down_reg;
        s1_valid_next   = 1'b0;
        s1_addr_next    = rd_addr_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_read_next   = res_read_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;
        m_read_next     = m_read_reg;
        m_count_next    = m_count_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = s1_addr_reg;
        mem_wr_data     = mem_rd_data;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = rd_addr_reg;

        // second stage: data of the read issued last cycle
        if (s1_valid_reg) begin
            unique case (op_reg)
                ple_pkg::OP_INSERT: begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = s1_addr_reg + AW'(1);
                end
                ple_pkg::OP_DELETE: begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = s1_addr_reg - AW'(1);
                end
                ple_pkg::OP_SEARCH: begin
                    if (match) begin
                        res_status_next = ple_pkg::STAT_OK;
                        res_found_next  = 7'(s1_addr_reg);
                    end
                end
                ple_pkg::OP_READ: begin
                    res_read_next = mem_rd_data;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_operation;
                    val_next        = s_value;
                    res_status_next = ple_pkg::STAT_OK;
                    res_found_next  = '0;
                    res_read_next   = '0;
                    state_next      = S_RESP;
                    unique case (s_operation)
                        ple_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        ple_pkg::OP_INSERT: begin
                            if (count_ext >= DEPTH_EXT) begin
                                res_status_next = ple_pkg::STAT_OVERFLOW;
                            end else if (s_position == 8'd0
                                         || pos_ext > count_ext + CMPW'(1)) begin
                                res_status_next = ple_pkg::STAT_BADPOS;
                            end else begin
                                count_next    = count_reg + CW'(1);
                                pos_addr_next = pos_m1;
                                if (pos_ext == count_ext + CMPW'(1)) begin
                                    state_next = S_FILL;
                                end else begin
                                    // shift up, top entry first
                                    rd_addr_next = cnt_m1;
                                    last_next    = pos_m1;
                                    down_next    = 1'b1;
                                    state_next   = S_WALK;
                                end
                            end
                        end
                        ple_pkg::OP_DELETE: begin
                            if (count_reg == '0) begin
                                res_status_next = ple_pkg::STAT_EMPTY;
                            end else if (s_position == 8'd0 || pos_ext > count_ext) begin
                                res_status_next = ple_pkg::STAT_BADPOS;
                            end else begin
                                count_next = count_reg - CW'(1);
                                if (pos_ext != count_ext) begin
                                    rd_addr_next = AW'(pos_ext);
                                    last_next    = cnt_m1;
                                    down_next    = 1'b0;
                                    state_next   = S_WALK;
                                end
                            end
                        end
                        ple_pkg::OP_SEARCH: begin
                            if (count_reg == '0) begin
                                res_status_next = ple_pkg::STAT_EMPTY;
                            end else begin
                                res_status_next = ple_pkg::STAT_NOTFOUND;
                                rd_addr_next    = '0;
                                last_next       = cnt_m1;
                                down_next       = 1'b0;
                                state_next      = S_WALK;
                            end
                        end
                        ple_pkg::OP_READ: begin
                            if (count_reg == '0) begin
                                res_status_next = ple_pkg::STAT_EMPTY;
                            end else if (s_position == 8'd0 || pos_ext > count_ext) begin
                                res_status_next = ple_pkg::STAT_BADPOS;
                            end else begin
                                rd_addr_next = pos_m1;
                                last_next    = pos_m1;
                                down_next    = 1'b0;
                                state_next   = S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (match) begin
                    state_next = S_RESP;
                end else begin
                    mem_rd_en     = 1'b1;
                    s1_valid_next = 1'b1;
                    s1_addr_next  = rd_addr_reg;
                    if (rd_addr_reg == last_reg) begin
                        state_next = S_DRAIN;
                    end else begin
                        rd_addr_next = down_reg ? rd_addr_reg - AW'(1)
                                                : rd_addr_reg + AW'(1);
                    end
                end
            end
            S_DRAIN: begin
                state_next = (op_reg == ple_pkg::OP_INSERT) ? S_FILL : S_RESP;
            end
            S_FILL: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_addr_reg;
                mem_wr_data = val_reg;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_found_next  = res_found_reg;
                    m_read_next   = res_read_reg;
                    m_count_next  = 8'(count_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        rd_addr_reg    <= rd_addr_next;
        last_reg       <= last_next;
        pos_addr_reg   <= pos_addr_next;
        down_reg       <= down_next;
        s1_addr_reg    <= s1_addr_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_read_reg   <= res_read_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_read_reg     <= m_read_next;
        m_count_reg    <= m_count_next;
    end

    // list never grows past the memory
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // shift write must never hit the entry being read in the same cycle
    a_no_rw_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("read and write to the same entry");

    // a new request is only taken once the read pipeline has drained
    a_accept_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !s1_valid_reg)
        else $error("request accepted with a read in flight");

    // a request transfer always leads to the sequencer leaving idle
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after a request");

endmodule

`default_nettype wire
